@@ sv/stepper_button_segment_sequencer_defines.svh @@
// Assertion macros shared by the stepper sequencer modules.
`ifndef STEPPER_BUTTON_SEGMENT_SEQUENCER_DEFINES_SVH
`define STEPPER_BUTTON_SEGMENT_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst is high.
`define SBSS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sbss check failed");
// Next-cycle implication, sampled on clk, off while rst is high.
`define SBSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sbss check failed");
`else
`define SBSS_ASSERT_NOW(label, ante, cons)
`define SBSS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ sv/sbss_pkg.sv @@
// Types, codes and constants for the stepper sequencer.
package sbss_pkg;

  localparam int CfgIndexWidth = 8;
  localparam int CfgDataWidth  = 8;

  // Register indexes on the configuration port
  localparam logic [CfgIndexWidth-1:0] CFG_PHASE_TICKS       = 8'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_STEPS_PER_SEGMENT = 8'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_SEGMENTS_PER_RUN  = 8'd2;
  localparam logic [CfgIndexWidth-1:0] CFG_BLINK_TICKS       = 8'd3;

  // Control state codes
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ARM   = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;
  localparam logic [2:0] ST_BLINK = 3'd3;
  localparam logic [2:0] ST_HALT  = 3'd4;

  // Full-step coil sequence
  localparam logic [3:0] COIL_TABLE [4] = '{4'b1100, 4'b0110, 4'b0011, 4'b1001};

  localparam logic [7:0] PHASE_TICKS_RESET       = 8'd1;
  localparam logic [7:0] STEPS_PER_SEGMENT_RESET = 8'd64;
  localparam logic [3:0] SEGMENTS_PER_RUN_RESET  = 4'd8;
  localparam logic [7:0] BLINK_TICKS_RESET       = 8'd35;

  typedef struct packed {
    logic [7:0] phase_ticks;
    logic [7:0] steps_per_segment;
    logic [3:0] segments_per_run;
    logic [7:0] blink_ticks;
  } sbss_cfg_t;

  typedef struct packed {
    logic [3:0] coil_pattern;
    logic       led_on;
    logic       motor_running;
  } sbss_result_t;

endpackage

@@ sv/sbss_ifs.sv @@
// Handshake channel interfaces for the stepper sequencer.
interface sbss_in_if;
  logic valid;
  logic ready;
  logic button_level;
  modport source (output valid, output button_level, input ready);
  modport sink   (input valid, input button_level, output ready);
endinterface

interface sbss_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] coil_pattern;
  logic       led_on;
  logic       motor_running;
  modport source (output valid, output coil_pattern, output led_on, output motor_running,
                  input ready);
  modport sink   (input valid, input coil_pattern, input led_on, input motor_running,
                  output ready);
endinterface

interface sbss_cfg_if import sbss_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [CfgIndexWidth-1:0] index;
  logic [CfgDataWidth-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/sbss_core.sv @@
// Sequencer state machine: one tick per accepted word, result for that tick.
`include "stepper_button_segment_sequencer_defines.svh"

module sbss_core import sbss_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         advance,
  input  logic         button_level,
  input  sbss_cfg_t    cfg,
  output sbss_result_t res
);

  logic [2:0] control_state, control_state_next;
  logic [1:0] phase_index, phase_index_next;
  logic [7:0] step_count, step_count_next;
  logic [3:0] segment_count, segment_count_next;
  logic [7:0] tick_count, tick_count_next;
  logic [3:0] held_pattern, held_pattern_next;

  logic       pressed;
  logic [8:0] tick_inc;
  logic [8:0] step_inc;
  logic [4:0] seg_inc;
  logic [3:0] coil_now;

  assign pressed  = !button_level;
  assign tick_inc = {1'b0, tick_count} + 9'd1;
  assign step_inc = {1'b0, step_count} + 9'd1;
  assign seg_inc  = {1'b0, segment_count} + 5'd1;
  assign coil_now = COIL_TABLE[phase_index];

  always_comb begin
    control_state_next = control_state;
    phase_index_next   = phase_index;
    step_count_next    = step_count;
    segment_count_next = segment_count;
    tick_count_next    = tick_count;
    held_pattern_next  = held_pattern;
    res                = '0;
    unique case (control_state)
      ST_ARM: begin
        if (!pressed) begin
          control_state_next = ST_RUN;
          phase_index_next   = '0;
          step_count_next    = '0;
          segment_count_next = '0;
          tick_count_next    = '0;
          held_pattern_next  = '0;
        end
      end
      ST_RUN: begin
        // a press at a step start halts the run
        if (phase_index == 2'd0 && tick_count == 8'd0 && pressed) begin
          control_state_next = ST_HALT;
          res.coil_pattern   = held_pattern;
        end else begin
          res.motor_running = 1'b1;
          res.coil_pattern  = coil_now;
          held_pattern_next = coil_now;
          if (tick_inc >= {1'b0, cfg.phase_ticks}) begin
            tick_count_next = '0;
            if (phase_index == 2'd3) begin
              phase_index_next = '0;
              if (step_inc >= {1'b0, cfg.steps_per_segment}) begin
                step_count_next    = '0;
                control_state_next = ST_BLINK;
              end else begin
                step_count_next = step_inc[7:0];
              end
            end else begin
              phase_index_next = phase_index + 2'd1;
            end
          end else begin
            tick_count_next = tick_inc[7:0];
          end
        end
      end
      ST_BLINK: begin
        res.motor_running = 1'b1;
        res.led_on        = 1'b1;
        res.coil_pattern  = held_pattern;
        if (tick_inc >= {1'b0, cfg.blink_ticks}) begin
          tick_count_next = '0;
          if (seg_inc >= {1'b0, cfg.segments_per_run}) begin
            segment_count_next = '0;
            control_state_next = ST_IDLE;
          end else begin
            segment_count_next = seg_inc[3:0];
            control_state_next = ST_RUN;
          end
        end else begin
          tick_count_next = tick_inc[7:0];
        end
      end
      ST_HALT: begin
        res.coil_pattern = held_pattern;
        if (!pressed) control_state_next = ST_IDLE;
      end
      default: begin
        control_state_next = pressed ? ST_ARM : ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_state <= ST_IDLE;
      phase_index   <= '0;
      step_count    <= '0;
      segment_count <= '0;
      tick_count    <= '0;
      held_pattern  <= '0;
    end else if (advance) begin
      control_state <= control_state_next;
      phase_index   <= phase_index_next;
      step_count    <= step_count_next;
      segment_count <= segment_count_next;
      tick_count    <= tick_count_next;
      held_pattern  <= held_pattern_next;
    end
  end

  `SBSS_ASSERT_NOW(a_led_within_run, res.led_on, res.motor_running)
  `SBSS_ASSERT_NOW(a_idle_coils_off, control_state == ST_IDLE, res.coil_pattern == 4'd0)
  `SBSS_ASSERT_NEXT(a_arm_release_starts,
                    advance && control_state == ST_ARM && button_level,
                    control_state == ST_RUN && held_pattern == 4'd0 && tick_count == 8'd0)
  `SBSS_ASSERT_NEXT(a_hold_without_tick, !advance,
                    $stable(control_state) && $stable(tick_count) && $stable(held_pattern))

endmodule

@@ sv/stepper_button_segment_sequencer.sv @@
// Top level of the button-controlled full-step stepper sequencer.
// Each input word is one timer tick carrying the raw active-low button sample;
// each tick yields exactly one result word (coil_pattern, led_on,
// motor_running) describing that tick. The state machine and its counters
// update in a single pass at the input handshake, and the result goes into a
// two-entry output buffer, so the block sustains one word per cycle and
// in_ch.ready drops only while both buffer entries wait on the output side.
// Configuration writes take effect at once and are always accepted; indexes
// beyond the four registers are ignored.
`include "stepper_button_segment_sequencer_defines.svh"

module stepper_button_segment_sequencer import sbss_pkg::*; (
  input logic        clk,
  input logic        rst,
  sbss_in_if.sink    in_ch,
  sbss_out_if.source out_ch,
  sbss_cfg_if.sink   cfg_ch
);

  sbss_cfg_t    cfg;
  sbss_result_t res;
  sbss_result_t slot0, slot1;
  logic [1:0]   count;
  logic         push, pop;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_ticks       <= PHASE_TICKS_RESET;
      cfg.steps_per_segment <= STEPS_PER_SEGMENT_RESET;
      cfg.segments_per_run  <= SEGMENTS_PER_RUN_RESET;
      cfg.blink_ticks       <= BLINK_TICKS_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_PHASE_TICKS:       cfg.phase_ticks       <= cfg_ch.data;
        CFG_STEPS_PER_SEGMENT: cfg.steps_per_segment <= cfg_ch.data;
        CFG_SEGMENTS_PER_RUN:  cfg.segments_per_run  <= cfg_ch.data[3:0];
        CFG_BLINK_TICKS:       cfg.blink_ticks       <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (count != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = out_ch.valid && out_ch.ready;

  sbss_core u_core (
    .clk          (clk),
    .rst          (rst),
    .advance      (push),
    .button_level (in_ch.button_level),
    .cfg          (cfg),
    .res          (res)
  );

  // two-entry output buffer, slot0 is the head
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      unique case ({push, pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case ({push, pop})
      2'b10: begin
        if (count == 2'd0) slot0 <= res;
        else slot1 <= res;
      end
      2'b01: slot0 <= slot1;
      2'b11: begin
        if (count == 2'd1) begin
          slot0 <= res;
        end else begin
          slot0 <= slot1;
          slot1 <= res;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid         = (count != 2'd0);
  assign out_ch.coil_pattern  = slot0.coil_pattern;
  assign out_ch.led_on        = slot0.led_on;
  assign out_ch.motor_running = slot0.motor_running;

  `SBSS_ASSERT_NOW(a_count_in_range, 1'b1, count != 2'd3)
  `SBSS_ASSERT_NEXT(a_push_fills, push && !pop, out_ch.valid)
  `SBSS_ASSERT_NEXT(a_full_holds_head, count == 2'd2 && !pop, $stable(slot0) && !in_ch.ready)

endmodule

@@ tb/stepper_button_segment_sequencer_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the button-driven full-step stepper sequencer.
module stepper_button_segment_sequencer_tb;
  import sbss_pkg::*;

  localparam logic [CfgIndexWidth-1:0] CFG_FIRST_UNUSED = CFG_BLINK_TICKS + 8'd1;
  localparam int TICK_GOAL = 600;

  // Predicts the coil/LED drive of every tick and checks the words that come out.
  class drive_scoreboard;
    sbss_cfg_t    regs;
    logic [2:0]   ctl_state;
    logic [1:0]   phase_idx;
    logic [7:0]   step_cnt;
    logic [3:0]   seg_cnt;
    logic [7:0]   tick_cnt;
    logic [3:0]   held_coils;
    sbss_result_t expected_drive_q[$];
    int           errors;

    function new();
      errors = 0;
      regs.phase_ticks       = PHASE_TICKS_RESET;
      regs.steps_per_segment = STEPS_PER_SEGMENT_RESET;
      regs.segments_per_run  = SEGMENTS_PER_RUN_RESET;
      regs.blink_ticks       = BLINK_TICKS_RESET;
      ctl_state  = ST_IDLE;
      phase_idx  = '0;
      step_cnt   = '0;
      seg_cnt    = '0;
      tick_cnt   = '0;
      held_coils = '0;
    endfunction

    function void write_reg(logic [CfgIndexWidth-1:0] idx, logic [CfgDataWidth-1:0] data);
      case (idx)
        CFG_PHASE_TICKS:       regs.phase_ticks = data;
        CFG_STEPS_PER_SEGMENT: regs.steps_per_segment = data;
        CFG_SEGMENTS_PER_RUN:  regs.segments_per_run = data[3:0];
        CFG_BLINK_TICKS:       regs.blink_ticks = data;
        default: ;
      endcase
    endfunction

    function void note_tick(logic level);
      sbss_result_t drv;
      logic         pressed;
      logic [8:0]   nxt;
      pressed = !level;
      drv = '0;
      case (ctl_state)
        ST_ARM: begin
          if (!pressed) begin
            ctl_state  = ST_RUN;
            phase_idx  = '0;
            step_cnt   = '0;
            seg_cnt    = '0;
            tick_cnt   = '0;
            held_coils = '0;
          end
        end
        ST_RUN: begin
          // a press only counts at the very start of a step
          if (phase_idx == 2'd0 && tick_cnt == 8'd0 && pressed) begin
            ctl_state = ST_HALT;
            drv.coil_pattern = held_coils;
          end else begin
            drv.motor_running = 1'b1;
            drv.coil_pattern  = COIL_TABLE[phase_idx];
            held_coils        = drv.coil_pattern;
            nxt = tick_cnt + 9'd1;
            if (nxt >= regs.phase_ticks) begin
              tick_cnt = '0;
              if (phase_idx == 2'd3) begin
                phase_idx = '0;
                nxt = step_cnt + 9'd1;
                if (nxt >= regs.steps_per_segment) begin
                  step_cnt  = '0;
                  ctl_state = ST_BLINK;
                end else begin
                  step_cnt = nxt[7:0];
                end
              end else begin
                phase_idx = phase_idx + 2'd1;
              end
            end else begin
              tick_cnt = nxt[7:0];
            end
          end
        end
        ST_BLINK: begin
          drv.motor_running = 1'b1;
          drv.led_on        = 1'b1;
          drv.coil_pattern  = held_coils;
          nxt = tick_cnt + 9'd1;
          if (nxt >= regs.blink_ticks) begin
            tick_cnt = '0;
            nxt = seg_cnt + 9'd1;
            if (nxt >= regs.segments_per_run) begin
              seg_cnt   = '0;
              ctl_state = ST_IDLE;
            end else begin
              seg_cnt   = nxt[3:0];
              ctl_state = ST_RUN;
            end
          end else begin
            tick_cnt = nxt[7:0];
          end
        end
        ST_HALT: begin
          drv.coil_pattern = held_coils;
          if (!pressed) ctl_state = ST_IDLE;
        end
        default: ctl_state = pressed ? ST_ARM : ST_IDLE;
      endcase
      expected_drive_q.push_back(drv);
    endfunction

    function void check_drive(sbss_result_t got);
      sbss_result_t want;
      if (expected_drive_q.size() == 0) begin
        $display("%0t: unexpected drive word coil=%h led=%b run=%b", $time,
                 got.coil_pattern, got.led_on, got.motor_running);
        errors++;
        return;
      end
      want = expected_drive_q.pop_front();
      if (got.coil_pattern !== want.coil_pattern) begin
        $display("%0t: coil_pattern expected %h actual %h", $time,
                 want.coil_pattern, got.coil_pattern);
        errors++;
      end
      if (got.led_on !== want.led_on) begin
        $display("%0t: led_on expected %b actual %b", $time, want.led_on, got.led_on);
        errors++;
      end
      if (got.motor_running !== want.motor_running) begin
        $display("%0t: motor_running expected %b actual %b", $time,
                 want.motor_running, got.motor_running);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  sbss_in_if  in_ch();
  sbss_out_if out_ch();
  sbss_cfg_if cfg_ch();

  stepper_button_segment_sequencer DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  drive_scoreboard sb;
  int              ticks_sent;
  bit              hold_req;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 6);
    return $urandom_range(10, 25);
  endfunction

  task automatic send_tick(input logic level, input bit gaps_on);
    int idle;
    idle = gaps_on ? idle_gap() : 0;
    if (idle > 0) begin
      in_ch.valid = 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.button_level = level;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_tick(level);
    ticks_sent++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic write_cfg(input logic [CfgIndexWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] data);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic drain();
    while (sb.expected_drive_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Zero, one or the top of the field.
  function automatic logic [7:0] edge_value(logic [7:0] top);
    case ($urandom_range(0, 2))
      0: return 8'd0;
      1: return 8'd1;
      default: return top;
    endcase
  endfunction

  // Output side: random stalls, bursts of steady ready, and one long hold-off on request.
  initial begin
    int stall;
    int burst;
    int r;
    stall = 0;
    burst = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = 80;
      end
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        stall--;
      end else if (burst > 0) begin
        out_ch.ready = 1'b1;
        burst--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          burst = $urandom_range(20, 60);
          out_ch.ready = 1'b1;
        end else if (r < 25) begin
          stall = idle_gap();
          out_ch.ready = 1'b0;
        end else begin
          out_ch.ready = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin : collect_drive
    sbss_result_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.coil_pattern  = out_ch.coil_pattern;
      got.led_on        = out_ch.led_on;
      got.motor_running = out_ch.motor_running;
      sb.check_drive(got);
    end
  end

  initial begin
    // arm, halt before the first pattern, press mid-step, halt at a step start
    logic [0:11] halt_seq;
    // zeroed registers, two segments with blinks, back to idle
    logic [0:12] short_run_seq;
    int          phase_no;
    int          len;
    int          start;
    int          r;
    bit          gaps_on;
    bit          paused;
    bit          extreme;
    logic [7:0]  pt;
    logic [7:0]  sps;
    logic [7:0]  spr;
    logic [7:0]  blk;

    halt_seq      = 12'b0101_0110_0101;
    short_run_seq = 13'b0111_1111_1111_1;
    sb = new();
    rst                = 1'b1;
    hold_req           = 1'b0;
    ticks_sent         = 0;
    in_ch.valid        = 1'b0;
    in_ch.button_level = 1'b1;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = CFG_PHASE_TICKS;
    cfg_ch.data        = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < 12; i++) send_tick(halt_seq[i], 1'b0);
    drain();
    write_cfg(CFG_PHASE_TICKS, 8'd0);
    write_cfg(CFG_STEPS_PER_SEGMENT, 8'd0);
    write_cfg(CFG_SEGMENTS_PER_RUN, 8'h12);
    write_cfg(CFG_BLINK_TICKS, 8'd0);
    write_cfg(CFG_FIRST_UNUSED, 8'hA5);
    for (int i = 0; i < 13; i++) send_tick(short_run_seq[i], 1'b1);

    phase_no = 0;
    paused   = 1'b0;
    while (ticks_sent < TICK_GOAL) begin
      drain();
      extreme = (phase_no == 0) || (phase_no != 1 && $urandom_range(0, 4) == 0);
      if (phase_no == 0) begin
        pt  = 8'd255;
        sps = 8'd255;
        spr = 8'd15;
        blk = 8'd255;
      end else if (extreme) begin
        pt  = edge_value(8'd255);
        sps = edge_value(8'd255);
        spr = edge_value(8'd15);
        blk = edge_value(8'd255);
      end else begin
        pt  = 8'($urandom_range(0, 3));
        sps = 8'($urandom_range(0, 3));
        spr = 8'($urandom_range(0, 3));
        blk = 8'($urandom_range(0, 4));
      end
      // upper nibble of the segment count is dropped by the block
      spr[7:4] = 4'($urandom_range(0, 15));
      write_cfg(CFG_PHASE_TICKS, pt);
      write_cfg(CFG_STEPS_PER_SEGMENT, sps);
      write_cfg(CFG_SEGMENTS_PER_RUN, spr);
      write_cfg(CFG_BLINK_TICKS, blk);
      if ($urandom_range(0, 2) == 0)
        write_cfg(CfgIndexWidth'($urandom_range(CFG_FIRST_UNUSED, 255)),
                  CfgDataWidth'($urandom_range(0, 255)));

      len     = extreme ? $urandom_range(150, 300) : $urandom_range(25, 70);
      gaps_on = $urandom_range(0, 3) != 0;
      if (phase_no == 2) begin
        hold_req = 1'b1;
        gaps_on  = 1'b0;
      end
      start = ticks_sent;
      while (ticks_sent - start < len) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          // release, press, then let the run go with a rare stray press
          repeat ($urandom_range(1, 3)) send_tick(1'b1, gaps_on);
          repeat ($urandom_range(1, 4)) send_tick(1'b0, gaps_on);
          repeat ($urandom_range(5, 40)) send_tick($urandom_range(0, 19) != 0, gaps_on);
        end else if (r < 85) begin
          repeat ($urandom_range(1, 4)) send_tick(1'b0, gaps_on);
          repeat ($urandom_range(1, 6)) send_tick(1'b1, gaps_on);
        end else begin
          repeat ($urandom_range(1, 10)) send_tick(1'($urandom_range(0, 1)), gaps_on);
        end
        // hold the input once mid-phase until every word is back
        if (phase_no == 3 && !paused && ticks_sent - start >= len / 2) begin
          paused = 1'b1;
          drain();
        end
      end
      phase_no++;
    end

    drain();
    repeat (8) @(negedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
